### hw/rtl/cbae_pkg.sv
`default_nettype none

package cbae_pkg;

  localparam int unsigned TWidth    = 16;
  localparam int unsigned CtrlWidth = 24;
  localparam int unsigned PosWidth  = 24;
  localparam int unsigned TanWidth  = 27;

  // Bounds on the tangent that the curve can produce; TanMax is the largest one it reaches.
  localparam logic signed [TanWidth-1:0] TanMin = -27'sd50331648;
  localparam logic signed [TanWidth-1:0] TanMax = 27'sd50331645;

endpackage

`default_nettype wire

### hw/rtl/cbae_if.sv
`default_nettype none

interface cbae_item_if;
  logic                                        valid;
  logic                                        ready;
  logic        [cbae_pkg::TWidth-1:0]          t_frac;
  logic signed [cbae_pkg::CtrlWidth-1:0]       ctrl_start;
  logic signed [cbae_pkg::CtrlWidth-1:0]       ctrl_exit;
  logic signed [cbae_pkg::CtrlWidth-1:0]       ctrl_entry;
  logic signed [cbae_pkg::CtrlWidth-1:0]       ctrl_end;

  modport source (
    output valid, t_frac, ctrl_start, ctrl_exit, ctrl_entry, ctrl_end,
    input  ready
  );
  modport sink (
    input  valid, t_frac, ctrl_start, ctrl_exit, ctrl_entry, ctrl_end,
    output ready
  );
endinterface

interface cbae_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cbae_pkg::PosWidth-1:0]  position;
  logic signed [cbae_pkg::TanWidth-1:0]  tangent;

  modport source (
    output valid, position, tangent,
    input  ready
  );
  modport sink (
    input  valid, position, tangent,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/cubic_bezier_axis_eval.sv
// Evaluates one axis of a cubic Bezier segment per word: position B(t) and, when follow_path
// is set, the derivative B'(t), both rounded to nearest with ties toward plus infinity. The
// block takes one word every cycle unless a stall at the output has filled the pipeline, and
// returns each result through the four register stages of the multiplier pipeline; a stall at
// the output holds each full stage that has no empty stage after it. follow_path resets to zero
// and should be written only while no word is in flight.
`default_nettype none

module cubic_bezier_axis_eval (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  cbae_item_if.sink       item_i,
  cbae_result_if.source   result_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i
);

  logic follow_path_q;
  logic follow_path_d;

  assign follow_path_d = cfg_we_i ? cfg_wdata_i : follow_path_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      follow_path_q <= 1'b0;
    end else begin
      follow_path_q <= follow_path_d;
    end
  end

  cbae_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .follow_path_i (follow_path_q),
    .item_i        (item_i),
    .result_o      (result_o)
  );

endmodule

`default_nettype wire

### hw/rtl/cbae_core.sv
`default_nettype none

module cbae_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       follow_path_i,
  cbae_item_if.sink       item_i,
  cbae_result_if.source   result_o
);

  localparam int unsigned AccWidth    = 72;
  localparam int unsigned TanAccWidth = 60;
  localparam int unsigned TanWidthC   = cbae_pkg::TanWidth;

  localparam logic signed [AccWidth-1:0]    PosRound = 72'sd1 <<< 47;
  localparam logic signed [TanAccWidth-1:0] TanRound = 60'sd1 <<< 31;

  // The curve is evaluated in power form around t:
  // B = p0 + 3 d1 t + 3 d2 t^2 + d3 t^3 and B' = 3 d1 + 6 d2 t + 3 d3 t^2.
  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_q, v2_q, v3_q, v4_q;

  assign rdy4 = !v4_q || result_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign item_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= item_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: control differences and t squared.
  logic signed [24:0] d1;
  logic signed [26:0] d1x3_d;
  logic signed [26:0] d2_d;
  logic signed [27:0] e1;
  logic signed [27:0] d3_d;
  logic        [31:0] t2_d;

  assign d1     = 25'(item_i.ctrl_exit) - 25'(item_i.ctrl_start);
  assign d1x3_d = 27'(d1) + (27'(d1) <<< 1);
  assign d2_d   = 27'(item_i.ctrl_start) - (27'(item_i.ctrl_exit) <<< 1)
                + 27'(item_i.ctrl_entry);
  assign e1     = 28'(item_i.ctrl_exit) - 28'(item_i.ctrl_entry);
  assign d3_d   = 28'(item_i.ctrl_end) - 28'(item_i.ctrl_start) + e1 + (e1 <<< 1);
  assign t2_d   = 32'(item_i.t_frac) * 32'(item_i.t_frac);

  logic        [15:0] t_q;
  logic        [31:0] t2_q;
  logic signed [23:0] p0_q;
  logic signed [26:0] d1x3_q;
  logic signed [26:0] d2_q;
  logic signed [27:0] d3_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && item_i.valid) begin
      t_q    <= item_i.t_frac;
      t2_q   <= t2_d;
      p0_q   <= item_i.ctrl_start;
      d1x3_q <= d1x3_d;
      d2_q   <= d2_d;
      d3_q   <= d3_d;
    end
  end

  // Stage 2: products with t and t squared.
  logic signed [16:0] t_s;
  logic signed [32:0] t2_s;
  logic signed [27:0] d2x3;
  logic signed [28:0] d2x6;
  logic signed [28:0] d3x3;
  logic signed [43:0] m1_d;
  logic signed [60:0] m2_d;
  logic        [47:0] t3_d;
  logic signed [45:0] n1_d;
  logic signed [61:0] n2_d;

  assign t_s  = $signed({1'b0, t_q});
  assign t2_s = $signed({1'b0, t2_q});
  assign d2x3 = 28'(d2_q) + (28'(d2_q) <<< 1);
  assign d2x6 = 29'(d2x3) <<< 1;
  assign d3x3 = 29'(d3_q) + (29'(d3_q) <<< 1);
  assign m1_d = 44'(d1x3_q) * 44'(t_s);
  assign m2_d = 61'(d2x3) * 61'(t2_s);
  assign t3_d = 48'(t2_q) * 48'(t_q);
  assign n1_d = 46'(d2x6) * 46'(t_s);
  assign n2_d = 62'(d3x3) * 62'(t2_s);

  logic signed [23:0] p0_2q;
  logic signed [26:0] d1x3_2q;
  logic signed [27:0] d3_2q;
  logic signed [43:0] m1_q;
  logic signed [60:0] m2_q;
  logic        [47:0] t3_q;
  logic signed [45:0] n1_q;
  logic signed [61:0] n2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      p0_2q   <= p0_q;
      d1x3_2q <= d1x3_q;
      d3_2q   <= d3_q;
      m1_q    <= m1_d;
      m2_q    <= m2_d;
      t3_q    <= t3_d;
      n1_q    <= n1_d;
      n2_q    <= n2_d;
    end
  end

  // Stage 3: cubic term in two halves, low position terms and the tangent.
  logic signed [52:0]             pplo_d, pphi_d;
  logic signed [AccWidth-1:0]     b_d;
  logic signed [TanAccWidth-1:0]  tsum;
  logic signed [TanWidthC-1:0]    tan_d;

  assign pplo_d = 53'(d3_2q) * 53'($signed({1'b0, t3_q[23:0]}));
  assign pphi_d = 53'(d3_2q) * 53'($signed({1'b0, t3_q[47:24]}));
  assign b_d    = (72'(p0_2q) <<< 48) + (72'(m1_q) <<< 32) + (72'(m2_q) <<< 16)
                + PosRound;
  assign tsum   = (60'(d1x3_2q) <<< 32) + (60'(n1_q) <<< 16) + 60'(n2_q) + TanRound;
  assign tan_d  = follow_path_i ? tsum[58:32] : '0;

  logic signed [52:0]            pplo_q, pphi_q;
  logic signed [AccWidth-1:0]    b_q;
  logic signed [TanWidthC-1:0]   tan3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      pplo_q <= pplo_d;
      pphi_q <= pphi_d;
      b_q    <= b_d;
      tan3_q <= tan_d;
    end
  end

  // Stage 4: final position sum into the output register.
  logic signed [AccWidth-1:0]               pos_sum;
  logic signed [cbae_pkg::PosWidth-1:0]     pos_q;
  logic signed [TanWidthC-1:0]              tan_q;

  assign pos_sum = b_q + (72'(pphi_q) <<< 24) + 72'(pplo_q);

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      pos_q <= pos_sum[71:48];
      tan_q <= tan3_q;
    end
  end

  assign result_o.valid    = v4_q;
  assign result_o.position = pos_q;
  assign result_o.tangent  = tan_q;

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones({v1_q, v2_q, v3_q, v4_q}) == 4 && !result_o.ready) |-> !item_i.ready)
    else $error("Input was offered room while the pipeline was full and stalled.");

  a_no_lost_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !v4_q) |=> v4_q)
    else $error("A word in stage three did not move into the empty output stage.");

  a_stall_holds_stage3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && v4_q && !result_o.ready) |=> (v3_q && $stable(b_q) && $stable(pplo_q)))
    else $error("Stage three changed while the output was stalled.");

  a_tangent_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (tan_q >= cbae_pkg::TanMin && tan_q <= cbae_pkg::TanMax))
    else $error("Tangent left the range the curve can produce.");

endmodule

`default_nettype wire

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TWidth    = cbae_pkg::TWidth;
  localparam int unsigned CtrlWidth = cbae_pkg::CtrlWidth;
  localparam int unsigned PosWidth  = cbae_pkg::PosWidth;
  localparam int unsigned TanWidth  = cbae_pkg::TanWidth;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned PhaseItems = 155;
  localparam int unsigned MaxReports = 40;

  localparam logic signed [CtrlWidth-1:0] CtrlMin = {1'b1, {(CtrlWidth-1){1'b0}}};
  localparam logic signed [CtrlWidth-1:0] CtrlMax = {1'b0, {(CtrlWidth-1){1'b1}}};

  typedef struct packed {
    logic        [TWidth-1:0]    t_frac;
    logic signed [CtrlWidth-1:0] ctrl_start;
    logic signed [CtrlWidth-1:0] ctrl_exit;
    logic signed [CtrlWidth-1:0] ctrl_entry;
    logic signed [CtrlWidth-1:0] ctrl_end;
  } curve_sample_t;

  typedef struct packed {
    logic signed [PosWidth-1:0] position;
    logic signed [TanWidth-1:0] tangent;
  } curve_point_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  cbae_item_if   item_if ();
  cbae_result_if result_if ();

  cubic_bezier_axis_eval i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_if),
    .result_o    (result_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  curve_sample_t samples_to_send[$];
  curve_point_t  points_due[$];
  logic          follow_path_q;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  int unsigned   mismatch_count;
  int unsigned   quiet_cycles;

  function automatic curve_point_t bezier_eval(curve_sample_t s, logic tangent_on);
    logic signed [95:0] t;
    logic signed [95:0] u;
    logic signed [95:0] p0;
    logic signed [95:0] p1;
    logic signed [95:0] p2;
    logic signed [95:0] p3;
    logic signed [95:0] acc;
    logic signed [95:0] slope;
    curve_point_t       r;
    t  = {80'd0, s.t_frac};
    u  = 96'sd65536 - t;
    p0 = 96'(s.ctrl_start);
    p1 = 96'(s.ctrl_exit);
    p2 = 96'(s.ctrl_entry);
    p3 = 96'(s.ctrl_end);
    acc = p0 * u * u * u + 3 * p1 * u * u * t + 3 * p2 * u * t * t + p3 * t * t * t
        + (96'sd1 <<< 47);
    acc = acc >>> 48;
    r.position = acc[PosWidth-1:0];
    r.tangent  = '0;
    if (tangent_on) begin
      slope = (p1 - p0) * u * u + 2 * (p2 - p1) * u * t + (p3 - p2) * t * t;
      slope = 3 * slope + (96'sd1 <<< 31);
      slope = slope >>> 32;
      r.tangent = slope[TanWidth-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [CtrlWidth-1:0] pick_ctrl(logic signed [CtrlWidth-1:0] base);
    logic signed [CtrlWidth-1:0] v;
    case ($urandom_range(9))
      0: v = CtrlMin;
      1: v = CtrlMax;
      2: v = CtrlWidth'($signed($urandom_range(16)) - 8);
      3, 4: v = CtrlWidth'(base + $signed($urandom_range(8191)) - 4096);
      default: v = CtrlWidth'($urandom());
    endcase
    return v;
  endfunction

  function automatic curve_sample_t random_sample();
    curve_sample_t s;
    case ($urandom_range(9))
      0: s.t_frac = '0;
      1: s.t_frac = '1;
      2: s.t_frac = 16'd1;
      3: s.t_frac = 16'h8000;
      default: s.t_frac = TWidth'($urandom());
    endcase
    s.ctrl_start = pick_ctrl(CtrlWidth'($urandom()));
    s.ctrl_exit  = pick_ctrl(s.ctrl_start);
    s.ctrl_entry = pick_ctrl(s.ctrl_exit);
    s.ctrl_end   = pick_ctrl(s.ctrl_entry);
    return s;
  endfunction

  task automatic add_sample(input logic [TWidth-1:0] t,
                            input logic signed [CtrlWidth-1:0] a,
                            input logic signed [CtrlWidth-1:0] b,
                            input logic signed [CtrlWidth-1:0] c,
                            input logic signed [CtrlWidth-1:0] d);
    curve_sample_t s;
    s.t_frac     = t;
    s.ctrl_start = a;
    s.ctrl_exit  = b;
    s.ctrl_entry = c;
    s.ctrl_end   = d;
    samples_to_send = {samples_to_send, s};
  endtask

  task automatic wait_until_idle();
    while (samples_to_send.size() != 0 || points_due.size() != 0 || item_if.valid) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_follow_path(input logic value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    follow_path_q = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : driver
    curve_sample_t word;
    if (item_if.valid && item_if.ready) begin
      word.t_frac     = item_if.t_frac;
      word.ctrl_start = item_if.ctrl_start;
      word.ctrl_exit  = item_if.ctrl_exit;
      word.ctrl_entry = item_if.ctrl_entry;
      word.ctrl_end   = item_if.ctrl_end;
      points_due = {points_due, bezier_eval(word, follow_path_q)};
    end
    if (!item_if.valid || item_if.ready) begin
      if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        word = samples_to_send.pop_front();
        item_if.valid      <= 1'b1;
        item_if.t_frac     <= word.t_frac;
        item_if.ctrl_start <= word.ctrl_start;
        item_if.ctrl_exit  <= word.ctrl_exit;
        item_if.ctrl_entry <= word.ctrl_entry;
        item_if.ctrl_end   <= word.ctrl_end;
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    curve_point_t want;
    if (result_if.valid && result_if.ready) begin
      if (points_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("%0t: unexpected word, expected none, actual position %0d tangent %0d",
                   $time, result_if.position, result_if.tangent);
        end
      end else begin
        want = points_due.pop_front();
        if (result_if.position !== want.position) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("%0t: position mismatch, expected %0d, actual %0d",
                     $time, want.position, result_if.position);
          end
        end
        if (result_if.tangent !== want.tangent) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("%0t: tangent mismatch, expected %0d, actual %0d",
                     $time, want.tangent, result_if.tangent);
          end
        end
      end
    end
    result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
        (samples_to_send.size() == 0 && points_due.size() == 0 && !item_if.valid)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = 1'b0;
    item_if.valid      = 1'b0;
    item_if.t_frac     = '0;
    item_if.ctrl_start = '0;
    item_if.ctrl_exit  = '0;
    item_if.ctrl_entry = '0;
    item_if.ctrl_end   = '0;
    result_if.ready    = 1'b0;
    follow_path_q      = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    mismatch_count     = 0;
    quiet_cycles       = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Field extremes, the largest tangents and rounding ties at t one half.
    write_follow_path(1'b1);
    add_sample('0, CtrlMax, CtrlMin, CtrlMax, CtrlMin);
    add_sample('0, CtrlMin, CtrlMax, '0, '0);
    add_sample('1, CtrlMin, CtrlMax, CtrlMin, CtrlMax);
    add_sample('1, CtrlMax, CtrlMax, CtrlMax, CtrlMin);
    add_sample('1, CtrlMax, CtrlMax, CtrlMax, CtrlMax);
    add_sample(16'h8000, CtrlMax, CtrlMax, CtrlMax, CtrlMax);
    add_sample(16'h8000, CtrlMin, CtrlMin, CtrlMin, CtrlMin);
    add_sample(16'd1, CtrlMin, CtrlMax, CtrlMax, CtrlMin);
    add_sample(16'h8000, 24'sd4, '0, '0, '0);
    add_sample(16'h8000, -24'sd4, '0, '0, '0);
    add_sample(16'h8000, '0, '0, '0, 24'sd2);
    add_sample(16'h8000, '0, '0, '0, -24'sd2);
    add_sample('0, '0, '0, '0, '0);
    add_sample(16'd43690, CtrlMin, CtrlMax, CtrlMin, CtrlMax);
    add_sample(16'd21845, CtrlMax, CtrlMin, CtrlMax, CtrlMin);
    wait_until_idle();

    for (int phase = 0; phase < 8; phase++) begin
      write_follow_path(phase[0]);
      case (phase / 2)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 71;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 71;
        end
        default: begin
          send_idle_pct  = 21;
          recv_stall_pct = 21;
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        samples_to_send = {samples_to_send, random_sample()};
      end
      wait_until_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_count == 0 && points_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
